>>> hdl/wf23_pkg.sv
package wf23_pkg;

  localparam int SampleW = 16;
  localparam int TapW    = 16;
  localparam int AccW    = 48;
  localparam int XformW  = SampleW + 1;
  localparam int WeightW = TapW + 2;
  localparam int ProdW   = XformW + WeightW;
  localparam int HalfW   = ProdW - 1;
  localparam int AddW    = ProdW + 3;
  localparam int SumW    = AccW + 1;
  localparam int CfgIdxW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TAP_MODE = 8'd0,
    REG_TAP_ZERO = 8'd1,
    REG_TAP_ONE  = 8'd2,
    REG_TAP_TWO  = 8'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_THREE_TAP = 1'b0,
    MODE_ONE_TAP   = 1'b1
  } tap_mode_t;

  typedef struct packed {
    tap_mode_t              mode;
    logic signed [TapW-1:0] g0;
    logic signed [TapW-1:0] g1;
    logic signed [TapW-1:0] g2;
  } taps_t;

endpackage

>>> hdl/wf23_cfg.sv
module wf23_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wf23_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [wf23_pkg::TapW-1:0]       cfg_data,
  output wf23_pkg::taps_t                 taps
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps.mode <= wf23_pkg::MODE_THREE_TAP;
      taps.g0   <= '0;
      taps.g1   <= '0;
      taps.g2   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (wf23_pkg::cfg_reg_t'(cfg_index))
        wf23_pkg::REG_TAP_MODE: taps.mode <= wf23_pkg::tap_mode_t'(cfg_data[0]);
        wf23_pkg::REG_TAP_ZERO: taps.g0   <= $signed(cfg_data);
        wf23_pkg::REG_TAP_ONE:  taps.g1   <= $signed(cfg_data);
        wf23_pkg::REG_TAP_TWO:  taps.g2   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/winograd_f2_3_tile_mac.sv
// Four-stage pipeline: input register, product register, partial-sum register,
// result register. Throughput is one transaction per cycle unless out_stall holds
// the pipeline, set by one 17x18 multiplier per product. Stages advance
// independently, so bubbles collapse under out_stall. Synchronous active-high rst
// empties the pipeline and clears taps to zero.
module winograd_f2_3_tile_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [wf23_pkg::SampleW-1:0]   sample_0,
  input  logic signed [wf23_pkg::SampleW-1:0]   sample_1,
  input  logic signed [wf23_pkg::SampleW-1:0]   sample_2,
  input  logic signed [wf23_pkg::SampleW-1:0]   sample_3,
  input  logic signed [wf23_pkg::AccW-1:0]      acc_even,
  input  logic signed [wf23_pkg::AccW-1:0]      acc_odd,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [wf23_pkg::AccW-1:0]      sum_even,
  output logic signed [wf23_pkg::AccW-1:0]      sum_odd,
  output logic                                  saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wf23_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [wf23_pkg::TapW-1:0]             cfg_data
);

  localparam int SampleW = wf23_pkg::SampleW;
  localparam int AccW    = wf23_pkg::AccW;
  localparam int XformW  = wf23_pkg::XformW;
  localparam int WeightW = wf23_pkg::WeightW;
  localparam int ProdW   = wf23_pkg::ProdW;
  localparam int HalfW   = wf23_pkg::HalfW;
  localparam int AddW    = wf23_pkg::AddW;
  localparam int SumW    = wf23_pkg::SumW;

  wf23_pkg::taps_t taps;

  wf23_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .taps      (taps)
  );

  logic v1, v2, v3;
  logic en1, en2, en3, en4;

  assign en4      = !out_valid || !out_stall;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  // stage 1: input register
  logic signed [SampleW-1:0] d0, d1, d2, d3;
  logic signed [AccW-1:0]    acc_e1, acc_o1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d0     <= sample_0;
      d1     <= sample_1;
      d2     <= sample_2;
      d3     <= sample_3;
      acc_e1 <= acc_even;
      acc_o1 <= acc_odd;
    end
  end

  // stage 2: transforms and products
  logic signed [XformW-1:0]  x0, x1, x2, x3;
  logic signed [XformW-1:0]  a0, a1, a2, a3;
  logic signed [WeightW-1:0] w0, w1, w2, w3;
  logic signed [WeightW-1:0] b0, b1, b2, b3;
  logic signed [ProdW-1:0]   p0, p1, p2, p3;
  logic signed [AccW-1:0]    acc_e2, acc_o2;

  always_comb begin
    x0 = XformW'(d0) - XformW'(d2);
    x1 = XformW'(d1) + XformW'(d2);
    x2 = XformW'(d2) - XformW'(d1);
    x3 = XformW'(d1) - XformW'(d3);
    w0 = WeightW'(taps.g0);
    w1 = WeightW'(taps.g0) + WeightW'(taps.g1) + WeightW'(taps.g2);
    w2 = WeightW'(taps.g0) - WeightW'(taps.g1) + WeightW'(taps.g2);
    w3 = WeightW'(taps.g2);
    if (taps.mode == wf23_pkg::MODE_ONE_TAP) begin
      a0 = XformW'(d1);
      a1 = '0;
      a2 = '0;
      a3 = -XformW'(d2);
      b0 = w0;
      b1 = '0;
      b2 = '0;
      b3 = w0;
    end else begin
      a0 = x0;
      a1 = x1;
      a2 = x2;
      a3 = x3;
      b0 = w0;
      b1 = w1;
      b2 = w2;
      b3 = w3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      p0     <= ProdW'(a0) * ProdW'(b0);
      p1     <= ProdW'(a1) * ProdW'(b1);
      p2     <= ProdW'(a2) * ProdW'(b2);
      p3     <= ProdW'(a3) * ProdW'(b3);
      acc_e2 <= acc_e1;
      acc_o2 <= acc_o1;
    end
  end

  // stage 3: output transform
  logic signed [HalfW-1:0] h1, h2;
  logic signed [AddW-1:0]  add_e, add_o;
  logic signed [AccW-1:0]  acc_e3, acc_o3;

  assign h1 = HalfW'(p1 >>> 1);
  assign h2 = HalfW'(p2 >>> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      add_e  <= AddW'(p0) + AddW'(h1) + AddW'(h2);
      add_o  <= AddW'(h1) - AddW'(h2) - AddW'(p3);
      acc_e3 <= acc_e2;
      acc_o3 <= acc_o2;
    end
  end

  // stage 4: accumulate and clip
  logic signed [SumW-1:0] se, so;
  logic                   ovf_e, ovf_o;
  logic signed [AccW-1:0] sat_e, sat_o;

  always_comb begin
    se    = SumW'(acc_e3) + SumW'(add_e);
    so    = SumW'(acc_o3) + SumW'(add_o);
    ovf_e = se[SumW-1] != se[SumW-2];
    ovf_o = so[SumW-1] != so[SumW-2];
    sat_e = se[SumW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    sat_o = so[SumW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      sum_even  <= ovf_e ? sat_e : se[AccW-1:0];
      sum_odd   <= ovf_o ? sat_o : so[AccW-1:0];
      saturated <= ovf_e || ovf_o;
    end
  end

endmodule

>>> tb/tb_winograd_f2_3_tile_mac.sv
module tb_winograd_f2_3_tile_mac;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SampleW = wf23_pkg::SampleW;
  localparam int AccW    = wf23_pkg::AccW;
  localparam int CfgIdxW = wf23_pkg::CfgIdxW;
  localparam int TapW    = wf23_pkg::TapW;

  localparam int NumRegs = 4;
  localparam int BlockItems = 50;
  localparam int Blocks = 15;

  localparam logic signed [SampleW-1:0] SampleHi = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SampleLo = 16'sh8000;
  localparam logic signed [AccW-1:0] AccHi = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [AccW-1:0] AccLo = 48'sh8000_0000_0000;
  localparam longint AccMax = (longint'(1) <<< (AccW - 1)) - 1;
  localparam longint AccMin = -AccMax - 1;

  typedef struct {
    logic signed [SampleW-1:0] sample_0;
    logic signed [SampleW-1:0] sample_1;
    logic signed [SampleW-1:0] sample_2;
    logic signed [SampleW-1:0] sample_3;
    logic signed [AccW-1:0]    acc_even;
    logic signed [AccW-1:0]    acc_odd;
  } tile_t;

  typedef struct {
    logic signed [AccW-1:0] sum_even;
    logic signed [AccW-1:0] sum_odd;
    logic                   saturated;
  } sums_t;

  typedef struct {
    logic            reload;
    wf23_pkg::taps_t taps;
    tile_t           tile;
    logic            known;
    sums_t           sums;
  } row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic signed [15:0]  sample_0;
  logic signed [15:0]  sample_1;
  logic signed [15:0]  sample_2;
  logic signed [15:0]  sample_3;
  logic signed [47:0]  acc_even;
  logic signed [47:0]  acc_odd;
  logic                out_valid;
  logic                out_stall;
  logic signed [47:0]  sum_even;
  logic signed [47:0]  sum_odd;
  logic                saturated;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [TapW-1:0]     cfg_data;

  wf23_pkg::taps_t taps_now;
  sums_t   due_sums[$];
  sums_t   head;
  row_t    plan[$];
  int      mismatches = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;

  winograd_f2_3_tile_mac dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_0  (sample_0),
    .sample_1  (sample_1),
    .sample_2  (sample_2),
    .sample_3  (sample_3),
    .acc_even  (acc_even),
    .acc_odd   (acc_odd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sum_even  (sum_even),
    .sum_odd   (sum_odd),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic sums_t mac_step(tile_t t, wf23_pkg::taps_t k);
    longint d0, d1, d2, d3, g0, g1, g2, m1, m2, add_e, add_o, se, so;
    sums_t r;
    d0 = t.sample_0;
    d1 = t.sample_1;
    d2 = t.sample_2;
    d3 = t.sample_3;
    g0 = $signed(k.g0);
    g1 = $signed(k.g1);
    g2 = $signed(k.g2);
    if (k.mode == wf23_pkg::MODE_THREE_TAP) begin
      m1 = ((d1 + d2) * (g0 + g1 + g2)) >>> 1;
      m2 = ((d2 - d1) * (g0 - g1 + g2)) >>> 1;
      add_e = (d0 - d2) * g0 + m1 + m2;
      add_o = m1 - m2 - (d1 - d3) * g2;
    end else begin
      add_e = d1 * g0;
      add_o = d2 * g0;
    end
    se = longint'($signed(t.acc_even)) + add_e;
    so = longint'($signed(t.acc_odd)) + add_o;
    r.saturated = (se > AccMax) || (se < AccMin) || (so > AccMax) || (so < AccMin);
    se = (se > AccMax) ? AccMax : (se < AccMin) ? AccMin : se;
    so = (so > AccMax) ? AccMax : (so < AccMin) ? AccMin : so;
    r.sum_even = se[AccW-1:0];
    r.sum_odd = so[AccW-1:0];
    return r;
  endfunction

  function automatic logic [SampleW-1:0] any_word();
    case ($urandom_range(7))
      0: return SampleHi;
      1: return SampleLo;
      2: return '0;
      3: return '1;
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic logic [AccW-1:0] any_acc();
    longint off;
    logic [31:0] r;
    off = longint'({2'($urandom_range(3)), $urandom});
    r = $urandom;
    case ($urandom_range(5))
      0: return AccW'(AccMax - off);
      1: return AccW'(AccMin + off);
      2: return AccW'({$urandom, $urandom});
      default: return {{(AccW - 32){r[31]}}, r};
    endcase
  endfunction

  function automatic tile_t any_tile();
    tile_t t;
    t.sample_0 = any_word();
    t.sample_1 = any_word();
    t.sample_2 = any_word();
    t.sample_3 = any_word();
    t.acc_even = any_acc();
    t.acc_odd = any_acc();
    return t;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TapW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      wf23_pkg::REG_TAP_MODE: taps_now.mode = wf23_pkg::tap_mode_t'(data[0]);
      wf23_pkg::REG_TAP_ZERO: taps_now.g0 = data;
      wf23_pkg::REG_TAP_ONE:  taps_now.g1 = data;
      wf23_pkg::REG_TAP_TWO:  taps_now.g2 = data;
      default: ;
    endcase
  endtask

  // junk writes to unused indexes bracket the real ones; mode carries junk upper bits
  task automatic load_taps(wf23_pkg::taps_t k);
    write_reg(CfgIdxW'($urandom_range(255, NumRegs)), TapW'($urandom));
    write_reg(wf23_pkg::REG_TAP_MODE, {15'($urandom), k.mode});
    write_reg(wf23_pkg::REG_TAP_ZERO, k.g0);
    write_reg(wf23_pkg::REG_TAP_ONE, k.g1);
    write_reg(wf23_pkg::REG_TAP_TWO, k.g2);
    write_reg(CfgIdxW'($urandom_range(255, NumRegs)), TapW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tile(tile_t t, logic known, sums_t sums);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_0 <= t.sample_0;
    sample_1 <= t.sample_1;
    sample_2 <= t.sample_2;
    sample_3 <= t.sample_3;
    acc_even <= t.acc_even;
    acc_odd <= t.acc_odd;
    do @(posedge clk); while (in_stall);
    if (known) begin
      due_sums.push_back(sums);
    end else begin
      due_sums.push_back(mac_step(t, taps_now));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_sums.size() == 0) begin
        $error("unexpected transaction: sum_even %0d sum_odd %0d", sum_even, sum_odd);
        mismatches++;
      end else begin
        head = due_sums.pop_front();
        if (sum_even !== head.sum_even) begin
          $error("sum_even: expected %0d, got %0d", head.sum_even, sum_even);
          mismatches++;
        end
        if (sum_odd !== head.sum_odd) begin
          $error("sum_odd: expected %0d, got %0d", head.sum_odd, sum_odd);
          mismatches++;
        end
        if (saturated !== head.saturated) begin
          $error("saturated: expected %0d, got %0d", head.saturated, saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin
    wf23_pkg::taps_t k;
    rst = 1'b1;
    in_valid = 1'b0;
    sample_0 = '0;
    sample_1 = '0;
    sample_2 = '0;
    sample_3 = '0;
    acc_even = '0;
    acc_odd = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    taps_now = '{wf23_pkg::MODE_THREE_TAP, '0, '0, '0};

    plan = '{
      '{1'b0, '{wf23_pkg::MODE_THREE_TAP, '0, '0, '0},
        '{SampleHi, SampleLo, SampleHi, SampleLo, 48'sd5, -48'sd7},
        1'b1, '{48'sd5, -48'sd7, 1'b0}},
      '{1'b0, '{wf23_pkg::MODE_THREE_TAP, '0, '0, '0},
        '{SampleLo, SampleHi, SampleLo, SampleHi, AccHi, AccLo},
        1'b1, '{AccHi, AccLo, 1'b0}},
      '{1'b1, '{wf23_pkg::MODE_ONE_TAP, 16'sd3, SampleHi, SampleLo},
        '{SampleHi, 16'sd100, -16'sd100, SampleLo, '0, '0},
        1'b1, '{48'sd300, -48'sd300, 1'b0}},
      '{1'b1, '{wf23_pkg::MODE_ONE_TAP, SampleLo, SampleHi, SampleHi},
        '{'0, SampleLo, SampleLo, '0, AccHi, AccHi},
        1'b1, '{AccHi, AccHi, 1'b1}},
      '{1'b0, '{wf23_pkg::MODE_ONE_TAP, SampleLo, SampleHi, SampleHi},
        '{'0, SampleHi, SampleHi, '0, AccLo, AccLo},
        1'b1, '{AccLo, AccLo, 1'b1}},
      '{1'b1, '{wf23_pkg::MODE_ONE_TAP, -16'sd2, SampleLo, SampleHi},
        '{SampleLo, 16'sd7, 16'sd9, SampleHi, '0, '0},
        1'b1, '{-48'sd14, -48'sd18, 1'b0}},
      '{1'b1, '{wf23_pkg::MODE_ONE_TAP, SampleHi, SampleLo, SampleLo},
        '{SampleLo, SampleHi, SampleLo, SampleHi, '0, '0}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b1, '{wf23_pkg::MODE_THREE_TAP, SampleHi, SampleHi, SampleHi},
        '{SampleHi, SampleLo, SampleHi, SampleLo, '0, '0}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b0, '{wf23_pkg::MODE_THREE_TAP, SampleHi, SampleHi, SampleHi},
        '{SampleLo, SampleHi, SampleLo, SampleHi, '0, '0}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b0, '{wf23_pkg::MODE_THREE_TAP, SampleHi, SampleHi, SampleHi},
        '{SampleLo, SampleLo, SampleHi, SampleHi, AccHi, AccLo}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b0, '{wf23_pkg::MODE_THREE_TAP, SampleHi, SampleHi, SampleHi},
        '{SampleHi, SampleHi, SampleLo, SampleLo, AccLo, AccHi}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b1, '{wf23_pkg::MODE_THREE_TAP, SampleLo, SampleLo, SampleLo},
        '{SampleHi, SampleLo, SampleHi, SampleLo, '0, '0}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b0, '{wf23_pkg::MODE_THREE_TAP, SampleLo, SampleLo, SampleLo},
        '{SampleLo, SampleLo, SampleLo, SampleLo, AccHi, AccHi}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b0, '{wf23_pkg::MODE_THREE_TAP, SampleLo, SampleLo, SampleLo},
        '{SampleHi, SampleHi, SampleHi, SampleHi, AccLo, AccLo}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b1, '{wf23_pkg::MODE_THREE_TAP, SampleHi, SampleLo, SampleHi},
        '{SampleLo, SampleHi, SampleHi, SampleLo, AccHi, AccLo}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b0, '{wf23_pkg::MODE_THREE_TAP, SampleHi, SampleLo, SampleHi},
        '{SampleHi, SampleLo, SampleLo, SampleHi, AccLo, AccHi}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b1, '{wf23_pkg::MODE_THREE_TAP, '0, '0, 16'sd1},
        '{'0, '0, -16'sd1, '0, '0, '0}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b0, '{wf23_pkg::MODE_THREE_TAP, '0, '0, 16'sd1},
        '{'0, 16'sd1, '0, 16'sd1, '0, '0}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b0, '{wf23_pkg::MODE_THREE_TAP, '0, '0, 16'sd1},
        '{'0, -16'sd1, -16'sd2, '0, '0, '0}, 1'b0, '{'0, '0, 1'b0}},
      '{1'b1, '{wf23_pkg::MODE_THREE_TAP, -16'sd1, 16'sd1, -16'sd1},
        '{16'sd3, -16'sd5, 16'sd7, -16'sd9, -48'sd1, 48'sd1}, 1'b0, '{'0, '0, 1'b0}}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 16;
    rx_idle_pct = 75;
    foreach (plan[i]) begin
      if (plan[i].reload) begin
        drain();
        load_taps(plan[i].taps);
      end
      send_tile(plan[i].tile, plan[i].known, plan[i].sums);
    end

    for (int b = 0; b < Blocks; b++) begin
      tx_idle_pct = (b < 5) ? 16 : (b < 10) ? 75 : 0;
      rx_idle_pct = (b < 5) ? 75 : (b < 10) ? 16 : 0;
      k.mode = ($urandom_range(3) == 0) ? wf23_pkg::MODE_ONE_TAP : wf23_pkg::MODE_THREE_TAP;
      k.g0 = any_word();
      k.g1 = any_word();
      k.g2 = any_word();
      drain();
      load_taps(k);
      for (int n = 0; n < BlockItems; n++) begin
        send_tile(any_tile(), 1'b0, '{'0, '0, 1'b0});
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS winograd_f2_3_tile_mac");
    end else begin
      $display("FAIL winograd_f2_3_tile_mac");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("FAIL winograd_f2_3_tile_mac");
    $finish;
  end

endmodule
